// ===== src/ssbk_pkg.sv =====
// Shared types and constants for the record sorter.
`default_nettype none
package ssbk_pkg;

  localparam int unsigned MAX_RECORDS_DEF = 64;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 6;

  // sort_order codes; the unused code keeps load order
  localparam logic [1:0] ORDER_KEEP  = 2'd0;
  localparam logic [1:0] ORDER_ASC   = 2'd1;
  localparam logic [1:0] ORDER_DESC  = 2'd2;
  localparam logic [1:0] ORDER_SPARE = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] salary_key;
    logic [TAG_W-1:0] record_tag;
    logic             last_record;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             last_out;
    logic             overflow;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_RD,
    ST_PASS_LD,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_NEXT,
    ST_EMIT_RD
  } state_e;

endpackage
`default_nettype wire

// ===== src/ssbk_mem.sv =====
// Record store: one write port, one read port with registered read data.
`default_nettype none
module ssbk_mem #(
  parameter int unsigned DEPTH = ssbk_pkg::MAX_RECORDS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire ssbk_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output ssbk_pkg::entry_t      rdata_o
);

  ssbk_pkg::entry_t mem_q [DEPTH];
  ssbk_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/ssbk_seq.sv =====
// Sequencer: load, selection sort passes over the shared compare, and emit.
`default_nettype none
module ssbk_seq #(
  parameter int unsigned MAX_RECORDS = ssbk_pkg::MAX_RECORDS_DEF,
  localparam int unsigned IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
  localparam int unsigned CNT_W = IDX_W + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ssbk_pkg::in_t    in_i,
  input  wire logic [1:0]       sort_order_i,
  output logic                  busy_o,
  output logic                  result_strobe_o,
  output ssbk_pkg::out_t        result_o,
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o,
  output ssbk_pkg::entry_t      wdata_o,
  output logic [IDX_W-1:0]      raddr_o,
  input  wire ssbk_pkg::entry_t rdata_i
);

  ssbk_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, sel_q, sel_d;
  ssbk_pkg::entry_t cur_q, cur_d, best_q, best_d;
  logic             emit_q, emit_d;
  logic             precedes;
  logic             sorting;
  logic             is_last;

  // shared compare unit
  always_comb begin
    case (sort_order_i)
      ssbk_pkg::ORDER_ASC:  precedes = rdata_i.key < best_q.key;
      ssbk_pkg::ORDER_DESC: precedes = rdata_i.key > best_q.key;
      default:              precedes = 1'b0;
    endcase
  end

  assign sorting = (sort_order_i == ssbk_pkg::ORDER_ASC) ||
                   (sort_order_i == ssbk_pkg::ORDER_DESC);
  assign is_last = (CNT_W'(j_q) + CNT_W'(1)) == cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssbk_pkg::ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    sel_q  <= sel_d;
    cur_q  <= cur_d;
    best_q <= best_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    emit_d  = 1'b0;
    i_d     = i_q;
    j_d     = j_q;
    sel_d   = sel_q;
    cur_d   = cur_q;
    best_d  = best_q;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = cur_q;
    raddr_o = '0;
    busy_o  = 1'b1;
    result_strobe_o = 1'b0;

    if (emit_q) begin
      // present entry j, prefetch j+1
      result_strobe_o = 1'b1;
      raddr_o = j_q + IDX_W'(1);
      j_d     = j_q + IDX_W'(1);
      emit_d  = 1'b1;
      if (is_last) begin
        emit_d  = 1'b0;
        cnt_d   = '0;
        drop_d  = 1'b0;
        state_d = ssbk_pkg::ST_IDLE;
      end
    end else begin
      unique case (state_q)
        ssbk_pkg::ST_IDLE: begin
          busy_o = 1'b0;
          if (start_i) begin
            if (cnt_q < CNT_W'(MAX_RECORDS)) begin
              we_o    = 1'b1;
              waddr_o = cnt_q[IDX_W-1:0];
              wdata_o = '{key: in_i.salary_key, tag: in_i.record_tag};
              cnt_d   = cnt_q + CNT_W'(1);
            end else begin
              drop_d = 1'b1;
            end
            if (in_i.last_record) begin
              i_d = '0;
              if (sorting && (cnt_d >= CNT_W'(2))) begin
                state_d = ssbk_pkg::ST_PASS_RD;
              end else begin
                state_d = ssbk_pkg::ST_EMIT_RD;
              end
            end
          end
        end
        ssbk_pkg::ST_PASS_RD: begin
          raddr_o = i_q;
          state_d = ssbk_pkg::ST_PASS_LD;
        end
        ssbk_pkg::ST_PASS_LD: begin
          cur_d   = rdata_i;
          best_d  = rdata_i;
          sel_d   = i_q;
          j_d     = i_q + IDX_W'(1);
          raddr_o = i_q + IDX_W'(1);
          state_d = ssbk_pkg::ST_SCAN;
        end
        ssbk_pkg::ST_SCAN: begin
          // keep the first strictly better key
          if (precedes) begin
            best_d = rdata_i;
            sel_d  = j_q;
          end
          raddr_o = j_q + IDX_W'(1);
          if (is_last) begin
            state_d = ssbk_pkg::ST_SWAP_A;
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
        ssbk_pkg::ST_SWAP_A: begin
          if (sel_q != i_q) begin
            we_o    = 1'b1;
            waddr_o = sel_q;
            wdata_o = cur_q;
            state_d = ssbk_pkg::ST_SWAP_B;
          end else begin
            state_d = ssbk_pkg::ST_NEXT;
          end
        end
        ssbk_pkg::ST_SWAP_B: begin
          we_o    = 1'b1;
          waddr_o = i_q;
          wdata_o = best_q;
          state_d = ssbk_pkg::ST_NEXT;
        end
        ssbk_pkg::ST_NEXT: begin
          if ((CNT_W'(i_q) + CNT_W'(2)) < cnt_q) begin
            i_d     = i_q + IDX_W'(1);
            state_d = ssbk_pkg::ST_PASS_RD;
          end else begin
            state_d = ssbk_pkg::ST_EMIT_RD;
          end
        end
        ssbk_pkg::ST_EMIT_RD: begin
          raddr_o = '0;
          j_d     = '0;
          emit_d  = 1'b1;
        end
        default: begin
          state_d = ssbk_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign result_o = '{sorted_key: rdata_i.key, sorted_tag: rdata_i.tag,
                      last_out: is_last, overflow: drop_q};

  // no results while the block takes records
  a_no_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !result_strobe_o) else $error("result while idle");

  // the final result ends the run
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last_out) |=> (!busy_o && cnt_q == '0))
    else $error("run did not end after last result");

  // an accepted last record starts the sort or the emit
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_i.last_record) |=> busy_o)
    else $error("last record did not start the run");

  // swaps stay inside the loaded set
  a_swap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_o && busy_o) |-> (CNT_W'(waddr_o) < cnt_q))
    else $error("swap outside loaded records");

endmodule
`default_nettype wire

// ===== src/selection_sort_by_key.sv =====
// Top level of the record sorter: config register, sequencer and record store.
//
// Usage:
//   Records arrive on in_i; a transaction is accepted on a clock edge with
//   start_i high and busy_o low. Loading takes one record per cycle. Records
//   past MAX_RECORDS are dropped and flag overflow on the run.
//   A record with last_record set starts the run: busy_o rises and the store
//   is sorted by repeated passes over the single compare unit and the one
//   read port of the store: one pass per i = 0 .. n-2 (n records), each
//   swapping only when it finds a better key. Order modes other than
//   ascending or descending, and sets of one record, skip the sort.
//   Emit follows a prefetch state: one result per cycle on result_o,
//   each valid for exactly the one cycle that result_strobe_o is high; the
//   receiver cannot stall. last_out marks the final result, after which
//   busy_o falls and a fresh set may load.
//   The sort_order register is written over cfg_valid_i/cfg_ready_o; the
//   user writes it only while idle (unenforced); it resets to ascending.
//   Reset (rst_ni low) clears the record count, the overflow flag and the
//   sequencer; store contents are not cleared, only loaded entries are read.
`default_nettype none
module selection_sort_by_key #(
  parameter int unsigned MAX_RECORDS = ssbk_pkg::MAX_RECORDS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire ssbk_pkg::in_t in_i,
  output logic               result_strobe_o,
  output ssbk_pkg::out_t     result_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  logic [1:0]       sort_order_q;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  ssbk_pkg::entry_t wdata, rdata;

  // Config writes land at any time; the user keeps them to idle periods.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_order_q <= ssbk_pkg::ORDER_ASC;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sort_order_q <= cfg_data_i;
    end
  end

  // Sequencer drives the store and the result ports.
  ssbk_seq #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .in_i            (in_i),
    .sort_order_i    (sort_order_q),
    .busy_o          (busy_o),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .raddr_o         (raddr),
    .rdata_i         (rdata)
  );

  // Key and tag store, read data registered.
  ssbk_mem #(
    .DEPTH (MAX_RECORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for selection_sort_by_key: directed, random sets vs a sort predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = ssbk_pkg::MAX_RECORDS_DEF;
  // Quiet cycles allowed after the final result before the order register is touched.
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    ssbk_pkg::in_t rec;
    int unsigned   gap;  // idle cycles before this record is offered
  } feed_item_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_r = 1'b0;
  ssbk_pkg::in_t  rec_r = '0;
  logic           cfg_valid = 1'b0;
  logic [1:0]     cfg_data = ssbk_pkg::ORDER_ASC;
  logic           busy_o;
  logic           result_strobe_o;
  ssbk_pkg::out_t result_o;
  logic           cfg_ready_o;

  feed_item_t     record_feed[$];
  ssbk_pkg::out_t sorted_due[$];
  int unsigned idle_cnt = 0;
  int unsigned mismatches = 0;

  // Shadow copy of the block state, updated on every accepted record.
  logic [ssbk_pkg::KEY_W-1:0] shadow_key [CAP];
  logic [ssbk_pkg::TAG_W-1:0] shadow_tag [CAP];
  int unsigned                shadow_count = 0;
  logic                       shadow_dropped = 1'b0;
  logic [1:0]                 shadow_order = ssbk_pkg::ORDER_ASC;  // register resets to ascending

  selection_sort_by_key #(.MAX_RECORDS(CAP)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_r),
    .busy_o         (busy_o),
    .in_i           (rec_r),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Store one record; on the last mark, sort the held set and queue every
  // record of it as an expected result, then start a fresh set.
  function automatic void absorb_record(ssbk_pkg::in_t r);
    int unsigned n;
    int unsigned sel;
    logic [ssbk_pkg::KEY_W-1:0] k;
    logic [ssbk_pkg::TAG_W-1:0] t;
    logic take;
    ssbk_pkg::out_t o;
    if (shadow_count < CAP) begin
      shadow_key[shadow_count] = r.salary_key;
      shadow_tag[shadow_count] = r.record_tag;
      shadow_count++;
    end else begin
      // store full: drop the record, the last one too, and flag the run
      shadow_dropped = 1'b1;
    end
    if (!r.last_record) return;
    n = shadow_count;
    if (n >= 2 && (shadow_order == ssbk_pkg::ORDER_ASC ||
                   shadow_order == ssbk_pkg::ORDER_DESC)) begin
      for (int unsigned i = 0; i + 1 < n; i++) begin
        sel = i;
        for (int unsigned j = i + 1; j < n; j++) begin
          // strict compare keeps the first of equal keys
          take = (shadow_order == ssbk_pkg::ORDER_ASC) ? (shadow_key[j] < shadow_key[sel])
                                                       : (shadow_key[j] > shadow_key[sel]);
          if (take) sel = j;
        end
        if (sel != i) begin
          k = shadow_key[i];
          t = shadow_tag[i];
          shadow_key[i] = shadow_key[sel];
          shadow_tag[i] = shadow_tag[sel];
          shadow_key[sel] = k;
          shadow_tag[sel] = t;
        end
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      o.sorted_key = shadow_key[i];
      o.sorted_tag = shadow_tag[i];
      o.last_out   = (i + 1 == n);
      o.overflow   = shadow_dropped;
      sorted_due = {sorted_due, o};
    end
    shadow_count = 0;
    shadow_dropped = 1'b0;
  endfunction

  // Driver: offer queued records, hold each until the block accepts it.
  always @(posedge clk_i) begin
    feed_item_t nxt;
    if (!rst_ni) begin
      start_r  <= 1'b0;
      idle_cnt <= 0;
    end else begin
      if (start_r && !busy_o) absorb_record(rec_r);
      // the slot is free unless a record is still being held off by busy
      if (!start_r || !busy_o) begin
        if (record_feed.size() != 0 && idle_cnt >= record_feed[0].gap) begin
          nxt = record_feed.pop_front();
          rec_r    <= nxt.rec;
          start_r  <= 1'b1;
          idle_cnt <= 0;
        end else begin
          start_r <= 1'b0;
          if (record_feed.size() != 0) idle_cnt <= idle_cnt + 1;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected one.
  always @(posedge clk_i) begin
    ssbk_pkg::out_t want;
    if (rst_ni && result_strobe_o) begin
      if (sorted_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result key %0h tag %0d",
                                  result_o.sorted_key, result_o.sorted_tag));
      end else begin
        want = sorted_due.pop_front();
        if (result_o.sorted_key !== want.sorted_key)
          report_mismatch($sformatf("sorted_key %0h, want %0h",
                                    result_o.sorted_key, want.sorted_key));
        if (result_o.sorted_tag !== want.sorted_tag)
          report_mismatch($sformatf("sorted_tag %0d, want %0d",
                                    result_o.sorted_tag, want.sorted_tag));
        if (result_o.last_out !== want.last_out)
          report_mismatch($sformatf("last_out %b, want %b",
                                    result_o.last_out, want.last_out));
        if (result_o.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b",
                                    result_o.overflow, want.overflow));
      end
    end
  end

  task automatic push_rec(logic [ssbk_pkg::KEY_W-1:0] key, logic [ssbk_pkg::TAG_W-1:0] tag,
                          logic last, int unsigned gap);
    feed_item_t f;
    f.rec.salary_key  = key;
    f.rec.record_tag  = tag;
    f.rec.last_record = last;
    f.gap = gap;
    record_feed = {record_feed, f};
  endtask

  // Hold until everything is sent, every result is back and the block is
  // idle, then let DRAIN_CYCLES quiet cycles pass.
  task automatic settle();
    while (record_feed.size() != 0 || start_r || sorted_due.size() != 0 || busy_o)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One transaction on the configuration channel; only called while idle.
  task automatic set_order(logic [1:0] mode);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    shadow_order = mode;
  endtask

  // Equal keys at both extremes and in the middle, tags in load order.
  task automatic push_tie_set();
    push_rec(32'd5, 6'd1, 1'b0, 0);
    push_rec(32'hFFFF_FFFF, 6'd2, 1'b0, 1);
    push_rec(32'd0, 6'd3, 1'b0, 0);
    push_rec(32'd5, 6'd4, 1'b0, 2);
    push_rec(32'hFFFF_FFFF, 6'd5, 1'b0, 0);
    push_rec(32'd0, 6'd6, 1'b0, 0);
    push_rec(32'd5, 6'd7, 1'b1, 0);
  endtask

  task automatic push_short_set();
    push_rec(32'd3, 6'd0, 1'b0, 0);
    push_rec(32'd1, 6'd1, 1'b0, 0);
    push_rec(32'd2, 6'd2, 1'b1, 0);
  endtask

  // Stimulus: a directed part, then random phases with an order write between.
  initial begin
    int unsigned phase_items;
    int unsigned len;
    int unsigned style;
    int unsigned pick;
    logic        quiet;
    logic [ssbk_pkg::KEY_W-1:0] key;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: reset order (ascending), a set of one record, then ties.
    push_rec(32'hFFFF_FFFF, 6'd63, 1'b1, 0);
    push_tie_set();
    settle();
    set_order(ssbk_pkg::ORDER_DESC);
    push_tie_set();
    settle();
    set_order(ssbk_pkg::ORDER_KEEP);
    push_short_set();
    settle();
    set_order(ssbk_pkg::ORDER_SPARE);  // unused code keeps load order
    push_short_set();
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      // walk every code once, then draw at random
      set_order(ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)));
      quiet = ($urandom_range(0, 2) == 0);
      phase_items = 0;
      while (phase_items < 42) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) len = $urandom_range(CAP, CAP + 4);  // full store and overflow
        else if (pick < 4) len = $urandom_range(9, CAP - 1);
        else len = $urandom_range(1, 8);
        style = $urandom_range(0, 2);
        for (int unsigned i = 0; i < len; i++) begin
          case (style)
            0: key = $urandom;
            1: key = $urandom_range(0, 3);  // many equal keys
            default: begin
              pick = $urandom_range(0, 2);
              key = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
            end
          endcase
          push_rec(key, 6'($urandom_range(0, 63)), i + 1 == len,
                   quiet ? 0 : $urandom_range(0, 8));
        end
        phase_items += len;
      end
      // every phase ends with the sender paused until all results are back
      settle();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
